FILE: sv/sdaf_pkg.sv
package sdaf_pkg;

  localparam int unsigned NUM_CELLS = 10;
  localparam int unsigned DIGIT_POSITIONS_DEF = 10;
  localparam int unsigned MAG_W = 32;
  localparam int unsigned CMP_W = 34;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic                              neg;
    logic [MAG_W-1:0]                  rem;
    logic [NUM_CELLS-1:0][DIG_W-1:0]   digits;
  } stage_t;

  function automatic logic [CMP_W-1:0] digit_weight(int unsigned pos, int unsigned dig);
    logic [CMP_W-1:0] w;
    w = CMP_W'(dig);
    for (int unsigned i = 0; i < pos; i++) begin
      w = w * CMP_W'(10);
    end
    return w;
  endfunction

endpackage

FILE: sv/sdaf_cell.sv
module sdaf_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sdaf_pkg::stage_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sdaf_pkg::stage_t out_o
);
  import sdaf_pkg::*;

  localparam int unsigned Pow = NUM_CELLS - 1 - CellIdx;

  logic             vld_d, vld_q;
  stage_t           data_d, data_q;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] sub;
  logic [DIG_W-1:0] dig;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  // extract this position's digit against constant multiples of its weight
  always_comb begin
    rem_ext = CMP_W'(in_i.rem);
    dig     = '0;
    sub     = '0;
    for (int unsigned d = 1; d <= 9; d++) begin
      if (rem_ext >= digit_weight(Pow, d)) begin
        dig = DIG_W'(d);
        sub = digit_weight(Pow, d);
      end
    end
    data_d                 = in_i;
    data_d.rem             = MAG_W'(rem_ext - sub);
    data_d.digits[CellIdx] = dig;
  end

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: sv/sdaf_emit.sv
module sdaf_emit #(
  parameter int unsigned Positions = sdaf_pkg::DIGIT_POSITIONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sdaf_pkg::stage_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sdaf_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          out_last_o
);
  import sdaf_pkg::*;

  localparam int unsigned CntW = $clog2(Positions + 1);
  localparam int unsigned Base = NUM_CELLS - Positions;

  logic                vld_d, vld_q;
  logic [CntW-1:0]     cnt_d, cnt_q;
  logic [CHAR_W-1:0]   buf_d [Positions+1];
  logic [CHAR_W-1:0]   buf_q [Positions+1];
  logic [CHAR_W-1:0]   load_buf [Positions+1];
  logic [CntW-1:0]     load_cnt;
  logic [CHAR_W-1:0]   pos_char [Positions];
  logic [Positions:0]  nz_ext;
  logic [Positions:0]  seen;
  logic                last;
  logic                out_fire;
  logic                load;

  assign last        = (cnt_q == '0);
  assign out_valid_o = vld_q;
  assign out_char_o  = buf_q[0];
  assign out_last_o  = last;
  assign out_fire    = vld_q && out_ready_i;
  assign in_ready_o  = !vld_q || (out_ready_i && last);
  assign load        = in_valid_i && in_ready_o;

  // build the text of the kept digit window
  always_comb begin
    seen[0] = 1'b0;
    for (int unsigned k = 0; k < Positions; k++) begin
      nz_ext[k]  = (in_i.digits[Base+k] != '0);
      seen[k+1]  = seen[k] | nz_ext[k];
    end
    nz_ext[Positions] = 1'b0;
    for (int unsigned k = 0; k < Positions; k++) begin
      if (seen[k+1]) begin
        pos_char[k] = CHAR_ZERO + CHAR_W'(in_i.digits[Base+k]);
      end else if (in_i.neg && nz_ext[k+1]) begin
        pos_char[k] = CHAR_MINUS;
      end else begin
        pos_char[k] = CHAR_SPACE;
      end
    end
    if (!seen[Positions]) begin
      for (int unsigned j = 0; j < Positions; j++) begin
        load_buf[j] = CHAR_SPACE;
      end
      load_buf[Positions] = CHAR_ZERO;
      load_cnt = CntW'(Positions);
    end else if (in_i.neg && nz_ext[0]) begin
      load_buf[0] = CHAR_MINUS;
      for (int unsigned j = 0; j < Positions; j++) begin
        load_buf[j+1] = pos_char[j];
      end
      load_cnt = CntW'(Positions);
    end else begin
      for (int unsigned j = 0; j < Positions; j++) begin
        load_buf[j] = pos_char[j];
      end
      load_buf[Positions] = CHAR_SPACE;
      load_cnt = CntW'(Positions - 1);
    end
  end

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    buf_d = buf_q;
    if (out_fire) begin
      for (int unsigned j = 0; j < Positions; j++) begin
        buf_d[j] = buf_q[j+1];
      end
      buf_d[Positions] = CHAR_SPACE;
      cnt_d = cnt_q - CntW'(1);
      if (last) begin
        vld_d = 1'b0;
      end
    end
    if (load) begin
      vld_d = 1'b1;
      cnt_d = load_cnt;
      buf_d = load_buf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

FILE: sv/signed_decimal_ascii_formatter_unit.sv
// Signed decimal text formatter.
// Slave stream: one signed 32-bit value per transfer on s_axis_tdata.
// Master stream: one ASCII character per transfer on m_axis_tdata, text
// right-aligned in DIGIT_POSITIONS positions; leading zeros show as spaces,
// a minus sits just before the first digit of a negative value (as an extra
// leading character when the first digit fills the leftmost position), and
// zero gives all spaces then '0'. m_axis_tlast marks each value's final
// character. Only the lowest DIGIT_POSITIONS decimal digits are kept.
// A value passes through ten digit cells, one per decimal power, then the
// character register. Each value gives DIGIT_POSITIONS or DIGIT_POSITIONS + 1
// characters, sent from the character register one per transfer; the cell
// chain itself takes a value every cycle while the next stage is ready and
// buffers up to ten values ahead of the output.
// Reset clears all valid flags; the block accepts a value on the first
// cycle after reset. A stalled receiver holds the current character and
// fills the chain, after which s_axis_tready drops.
module signed_decimal_ascii_formatter_unit #(
  parameter int DIGIT_POSITIONS = sdaf_pkg::DIGIT_POSITIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] number_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast
);
  import sdaf_pkg::*;

  localparam int unsigned PosUsed = (DIGIT_POSITIONS < 1) ? 1 :
                                    ((DIGIT_POSITIONS > int'(NUM_CELLS)) ? NUM_CELLS :
                                     DIGIT_POSITIONS);

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic             chain_valid [NUM_CELLS+1];
  logic             chain_ready [NUM_CELLS+1];
  stage_t           chain_data  [NUM_CELLS+1];

  assign neg = s_axis_tdata[MAG_W-1];
  assign mag = neg ? (MAG_W'(0) - s_axis_tdata) : s_axis_tdata;

  assign chain_data[0] = '{neg: neg, rem: mag, digits: '0};

  assign chain_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = chain_ready[0];

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    sdaf_cell #(
      .CellIdx(c)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (chain_valid[c]),
      .in_ready_o (chain_ready[c]),
      .in_i       (chain_data[c]),
      .out_valid_o(chain_valid[c+1]),
      .out_ready_i(chain_ready[c+1]),
      .out_o      (chain_data[c+1])
    );
  end

  sdaf_emit #(
    .Positions(PosUsed)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (chain_valid[NUM_CELLS]),
    .in_ready_o (chain_ready[NUM_CELLS]),
    .in_i       (chain_data[NUM_CELLS]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == CHAR_SPACE || m_axis_tdata == CHAR_MINUS ||
                       (m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_NINE)))
    else $error("character outside space, minus and digits");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_NINE))
    else $error("final character is not a digit");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tdata == CHAR_MINUS) |=>
      (m_axis_tvalid && m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_NINE))
    else $error("minus not followed by a digit");

endmodule
